// ===== design/sls_pkg.sv =====
// ---------------------------------------------------------------------------
// sls_pkg: shared types and constants of the sequential list store
// opcodes, status codes, cell commands and the control bundle of the cell row
// ---------------------------------------------------------------------------
package sls_pkg;

	localparam int OPCODE_W = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	// wide enough for any index or count up to the largest capacity plus one
	localparam int LIST_IDX_W = 11;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_GET    = 3'd2,
		OP_APPEND = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_INS  = 2'd1,
		CMD_DEL  = 2'd2
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t              cmd;
		logic [LIST_IDX_W-1:0]  tgt;
		logic                   rd_en;
		logic                   adv;
	} cell_ctrl_t;

endpackage

// ===== design/sls_cell.sv =====
// ---------------------------------------------------------------------------
// sls_cell: one entry of the list
// holds a word, shifts up or down with its neighbors, and offers its word
// to the read tree when it is the selected entry
// ---------------------------------------------------------------------------
module sls_cell #(
	parameter int EW  = 32,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  sls_pkg::cell_ctrl_t  ctrl,
	input  logic [EW-1:0]        wdata,
	input  logic [EW-1:0]        left_data,
	input  logic [EW-1:0]        right_data,
	output logic [EW-1:0]        data,
	output logic [EW-1:0]        rd_s1
);
	import sls_pkg::*;

	localparam logic [LIST_IDX_W-1:0] MY_IDX = LIST_IDX_W'(IDX);

	logic [EW-1:0] data_q;
	logic [EW-1:0] data_d;
	logic          hit;
	logic          above;

	assign hit   = (MY_IDX == ctrl.tgt);
	assign above = (MY_IDX > ctrl.tgt);

	always_comb begin
		data_d = data_q;
		unique case (ctrl.cmd)
			CMD_INS: begin
				if (above) begin
					data_d = left_data;
				end else if (hit) begin
					data_d = wdata;
				end
			end
			CMD_DEL: begin
				if (above || hit) begin
					data_d = right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// read sees the word before this request's shift
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			rd_s1 <= (ctrl.rd_en && hit) ? data_q : '0;
		end
	end

	assign data = data_q;

endmodule

// ===== design/sls_rd_tree.sv =====
// ---------------------------------------------------------------------------
// sls_rd_tree: registered or-tree over the cell read words
// at most one cell offers a nonzero word, so an or picks it out
// ---------------------------------------------------------------------------
module sls_rd_tree #(
	parameter int N  = 64,
	parameter int EW = 32
) (
	input  logic            clk,
	input  logic            adv,
	input  logic [N*EW-1:0] rd_vec,
	output logic [EW-1:0]   rd_s3
);
	import sls_pkg::*;

	localparam int GROUP = 8;
	localparam int NG    = (N + GROUP - 1) / GROUP;

	logic [EW-1:0] grp_d [NG];
	logic [EW-1:0] grp_s2 [NG];
	logic [EW-1:0] all_d;

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int m = 0; m < GROUP; m++) begin
				if (g * GROUP + m < N) begin
					grp_d[g] = grp_d[g] | rd_vec[(g*GROUP+m)*EW +: EW];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grp_s2 <= grp_d;
		end
	end

	always_comb begin
		all_d = '0;
		for (int g = 0; g < NG; g++) begin
			all_d = all_d | grp_s2[g];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s3 <= all_d;
		end
	end

endmodule

// ===== design/sequential_list_store.sv =====
// ---------------------------------------------------------------------------
// sequential_list_store: fixed-capacity ordered list of words
// a read word passes the cell read register and then both or-tree registers to the output
// throughput: one request per cycle while the result register is not held; the cell row shifts all entries at once
// and reads go through a two-level registered or-tree
// reset: the entry count and all valid flags clear at once; entry words are
// left as they are and are never read before being written
// ---------------------------------------------------------------------------
module sequential_list_store #(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            request_valid,
	output logic                            request_stall,
	input  logic [sls_pkg::OPCODE_W-1:0]    opcode,
	input  logic [sls_pkg::POS_W-1:0]       position,
	input  logic [sls_pkg::VALUE_W-1:0]     value,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [sls_pkg::VALUE_W-1:0]     read_value,
	output logic [sls_pkg::STATUS_W-1:0]    status,
	output logic [sls_pkg::COUNT_W-1:0]     count,
	output logic                            is_empty
);
	import sls_pkg::*;

	localparam int EW = ELEMENT_WIDTH;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [LIST_IDX_W-1:0] CAP_X = LIST_IDX_W'(CAPACITY);

	logic                  adv;
	logic                  acc;
	logic [CW-1:0]         count_q;
	logic [LIST_IDX_W-1:0] cnt_x;
	logic [LIST_IDX_W-1:0] pos_x;
	logic [LIST_IDX_W-1:0] cnt_n;
	logic [LIST_IDX_W-1:0] tgt;
	cell_cmd_t             cmd;
	logic                  rd_en;
	status_t               st_d;
	cell_ctrl_t            ctrl;
	logic [EW-1:0]         wdata;
	logic [EW-1:0]         rd_s3;

	logic                  v_s1, v_s2;
	status_t               st_s1, st_s2, st_s3;
	logic [COUNT_W-1:0]    cnt_s1, cnt_s2, cnt_s3;
	logic                  emp_s1, emp_s2, emp_s3;

	logic [EW-1:0]         cell_data [CAPACITY];
	logic [CAPACITY*EW-1:0] rd_vec;

	// whole pipe moves unless the result register is held
	assign adv           = !result_valid || !result_stall;
	assign request_stall = !adv;
	assign acc           = request_valid && adv;

	assign cnt_x = LIST_IDX_W'(count_q);
	assign pos_x = LIST_IDX_W'(position);

	always_comb begin
		cmd   = CMD_HOLD;
		tgt   = '0;
		rd_en = 1'b0;
		st_d  = ST_OK;
		cnt_n = cnt_x;
		unique case (opcode)
			OP_INSERT: begin
				if (cnt_x == CAP_X) begin
					st_d = ST_FULL;
				end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
					st_d = ST_BADPOS;
				end else begin
					cmd   = CMD_INS;
					tgt   = pos_x - 1'b1;
					cnt_n = cnt_x + 1'b1;
				end
			end
			OP_DELETE: begin
				if (cnt_x == '0) begin
					st_d = ST_EMPTY;
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					st_d = ST_BADPOS;
				end else begin
					cmd   = CMD_DEL;
					tgt   = pos_x - 1'b1;
					rd_en = 1'b1;
					cnt_n = cnt_x - 1'b1;
				end
			end
			OP_GET: begin
				if (cnt_x == '0) begin
					st_d = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					st_d = ST_BADPOS;
				end else begin
					tgt   = pos_x;
					rd_en = 1'b1;
				end
			end
			OP_APPEND: begin
				// append is an insert just past the last entry
				if (cnt_x == CAP_X) begin
					st_d = ST_FULL;
				end else begin
					cmd   = CMD_INS;
					tgt   = cnt_x;
					cnt_n = cnt_x + 1'b1;
				end
			end
			OP_CLEAR: begin
				cnt_n = '0;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign ctrl.cmd   = acc ? cmd : CMD_HOLD;
	assign ctrl.tgt   = tgt;
	assign ctrl.rd_en = acc && rd_en;
	assign ctrl.adv   = adv;

	generate
		if (EW >= VALUE_W) begin : g_wide
			assign wdata      = EW'(value);
			assign read_value = rd_s3[VALUE_W-1:0];
		end else begin : g_narrow
			assign wdata      = value[EW-1:0];
			assign read_value = {{(VALUE_W-EW){1'b0}}, rd_s3};
		end
	endgenerate

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [EW-1:0] left_w;
			logic [EW-1:0] right_w;
			if (i == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = cell_data[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = cell_data[i+1];
			end
			sls_cell #(
				.EW  (EW),
				.IDX (i)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.wdata      (wdata),
				.left_data  (left_w),
				.right_data (right_w),
				.data       (cell_data[i]),
				.rd_s1      (rd_vec[i*EW +: EW])
			);
		end
	endgenerate

	sls_rd_tree #(
		.N  (CAPACITY),
		.EW (EW)
	) u_rd_tree (
		.clk    (clk),
		.adv    (adv),
		.rd_vec (rd_vec),
		.rd_s3  (rd_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= cnt_n[CW-1:0];
			end
			if (adv) begin
				v_s1         <= request_valid;
				v_s2         <= v_s1;
				result_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1  <= st_d;
			cnt_s1 <= cnt_n[COUNT_W-1:0];
			emp_s1 <= (cnt_n == '0);
			st_s2  <= st_s1;
			cnt_s2 <= cnt_s1;
			emp_s2 <= emp_s1;
			st_s3  <= st_s2;
			cnt_s3 <= cnt_s2;
			emp_s3 <= emp_s2;
		end
	end

	assign status   = st_s3;
	assign count    = cnt_s3;
	assign is_empty = emp_s3;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LIST_IDX_W'(count_q) <= CAP_X)
		else $error("entry count above capacity");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && opcode == OP_APPEND && LIST_IDX_W'(count_q) != CAP_X)
		|=> (LIST_IDX_W'(count_q) == LIST_IDX_W'($past(count_q)) + 1'b1))
		else $error("append did not grow the list");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_EMPTY) |-> is_empty)
		else $error("empty status on a nonempty list");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		request_stall |-> (result_valid && result_stall))
		else $error("request stalled with a free result register");

endmodule

// ===== verif/sequential_list_store_tb.sv =====
// ---------------------------------------------------------------------------
// sequential_list_store_tb: self-checking bench for the sequential list store
// a table of directed requests walks the list corners, then weighted random
// requests run under several idle and stall mixes and one long output hold;
// every result is checked in order against its typed row or else a model of the list
// ---------------------------------------------------------------------------
module sequential_list_store_tb;
	import sls_pkg::*;

	localparam int LIST_CAP    = 64;
	localparam int DIR_ROWS    = 27;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 10;
	localparam int POS_MAX     = (1 << POS_W) - 1;
	localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;
	localparam logic [VALUE_W-1:0]  ALL_ONES       = '1;

	typedef struct packed {
		logic [VALUE_W-1:0] rd;
		status_t            st;
		logic [COUNT_W-1:0] cnt;
		logic               empty;
	} list_result_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opc;
		logic [POS_W-1:0]    pos;
		logic [VALUE_W-1:0]  val;
		logic [6:0]          reps;	// nonzero: repeat with random words
		logic                typed;
		list_result_t        res;
	} dir_row_t;

	localparam list_result_t NO_CHECK = '0;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                request_valid = 1'b0;
	logic                request_stall;
	logic [OPCODE_W-1:0] opcode        = '0;
	logic [POS_W-1:0]    position      = '0;
	logic [VALUE_W-1:0]  value         = '0;
	logic                result_valid;
	logic                result_stall  = 1'b0;
	logic [VALUE_W-1:0]  read_value;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;

	// list model
	logic [VALUE_W-1:0] list_words [LIST_CAP];
	int                 list_len = 0;
	int                 peak_len = 0;
	list_result_t       pending_results [$];

	int idle_pct       = 0;
	int stall_pct      = 0;
	int hold_cycles    = 0;
	int cycle_count    = 0;
	int mismatch_count = 0;
	int requests_sent  = 0;
	int random_sent    = 0;
	int results_seen   = 0;
	int status_seen [4] = '{default: 0};

	dir_row_t dir_table [0:DIR_ROWS-1] = '{
		'{OP_GET,         7'd0,   32'h0,        7'd0,  1'b1, '{32'h0, ST_EMPTY,  7'd0,  1'b1}},
		'{OP_DELETE,      7'd1,   32'h0,        7'd0,  1'b1, '{32'h0, ST_EMPTY,  7'd0,  1'b1}},
		'{OP_INSERT,      7'd0,   ALL_ONES,     7'd0,  1'b1, '{32'h0, ST_BADPOS, 7'd0,  1'b1}},
		'{OP_INSERT,      7'd2,   ALL_ONES,     7'd0,  1'b1, '{32'h0, ST_BADPOS, 7'd0,  1'b1}},
		'{OP_SPARE_FIRST, 7'd127, ALL_ONES,     7'd0,  1'b1, '{32'h0, ST_OK,     7'd0,  1'b1}},
		'{OP_INSERT,      7'd1,   ALL_ONES,     7'd0,  1'b0, NO_CHECK},
		'{OP_APPEND,      7'd127, 32'h0,        7'd0,  1'b0, NO_CHECK},
		'{OP_INSERT,      7'd3,   32'hA5A5A5A5, 7'd0,  1'b0, NO_CHECK},
		'{OP_INSERT,      7'd2,   32'h5A5A5A5A, 7'd0,  1'b0, NO_CHECK},
		'{OP_GET,         7'd0,   32'h0,        7'd0,  1'b0, NO_CHECK},
		'{OP_GET,         7'd3,   32'h0,        7'd0,  1'b0, NO_CHECK},
		'{OP_GET,         7'd4,   32'h0,        7'd0,  1'b1, '{32'h0, ST_BADPOS, 7'd4,  1'b0}},
		'{OP_GET,         7'd127, 32'h0,        7'd0,  1'b1, '{32'h0, ST_BADPOS, 7'd4,  1'b0}},
		'{OP_DELETE,      7'd0,   32'h0,        7'd0,  1'b1, '{32'h0, ST_BADPOS, 7'd4,  1'b0}},
		'{OP_DELETE,      7'd5,   32'h0,        7'd0,  1'b1, '{32'h0, ST_BADPOS, 7'd4,  1'b0}},
		'{OP_DELETE,      7'd4,   32'h0,        7'd0,  1'b0, NO_CHECK},
		'{OP_DELETE,      7'd1,   32'h0,        7'd0,  1'b0, NO_CHECK},
		'{OP_SPARE_LAST,  7'd64,  32'h0,        7'd0,  1'b1, '{32'h0, ST_OK,     7'd2,  1'b0}},
		'{OP_CLEAR,       7'd127, ALL_ONES,     7'd0,  1'b1, '{32'h0, ST_OK,     7'd0,  1'b1}},
		'{OP_CLEAR,       7'd0,   32'h0,        7'd0,  1'b1, '{32'h0, ST_OK,     7'd0,  1'b1}},
		'{OP_APPEND,      7'd0,   32'h0,        7'd64, 1'b0, NO_CHECK},
		'{OP_INSERT,      7'd1,   ALL_ONES,     7'd0,  1'b1, '{32'h0, ST_FULL,   7'd64, 1'b0}},
		'{OP_APPEND,      7'd0,   ALL_ONES,     7'd0,  1'b1, '{32'h0, ST_FULL,   7'd64, 1'b0}},
		'{OP_INSERT,      7'd65,  32'h0,        7'd0,  1'b1, '{32'h0, ST_FULL,   7'd64, 1'b0}},
		'{OP_GET,         7'd64,  32'h0,        7'd0,  1'b1, '{32'h0, ST_BADPOS, 7'd64, 1'b0}},
		'{OP_GET,         7'd63,  32'h0,        7'd0,  1'b0, NO_CHECK},
		'{OP_DELETE,      7'd64,  32'h0,        7'd0,  1'b0, NO_CHECK}
	};

	sequential_list_store #(
		.CAPACITY      (LIST_CAP),
		.ELEMENT_WIDTH (VALUE_W)
	) dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// apply one request to the list model and return its result
	function automatic list_result_t apply_list_op(input logic [OPCODE_W-1:0] opc,
			input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] val);
		list_result_t r;
		int p;
		int k;
		r = '0;
		p = int'(pos);
		case (opc)
		OP_INSERT: begin
			if (list_len >= LIST_CAP) begin
				r.st = ST_FULL;
			end else if (p < 1 || p > list_len + 1) begin
				r.st = ST_BADPOS;
			end else begin
				for (k = list_len; k >= p; k--)
					list_words[k] = list_words[k - 1];
				list_words[p - 1] = val;
				list_len++;
			end
		end
		OP_DELETE: begin
			if (list_len == 0) begin
				r.st = ST_EMPTY;
			end else if (p < 1 || p > list_len) begin
				r.st = ST_BADPOS;
			end else begin
				r.rd = list_words[p - 1];
				for (k = p - 1; k + 1 < list_len; k++)
					list_words[k] = list_words[k + 1];
				list_len--;
			end
		end
		OP_GET: begin
			if (list_len == 0)
				r.st = ST_EMPTY;
			else if (p >= list_len)
				r.st = ST_BADPOS;
			else
				r.rd = list_words[p];
		end
		OP_APPEND: begin
			if (list_len >= LIST_CAP) begin
				r.st = ST_FULL;
			end else begin
				list_words[list_len] = val;
				list_len++;
			end
		end
		OP_CLEAR: begin
			list_len = 0;
		end
		default: ;
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		r.cnt   = COUNT_W'(list_len);
		r.empty = (list_len == 0);
		return r;
	endfunction

	// called on a rising edge; returns on the edge that takes the request
	task automatic send_request(input logic [OPCODE_W-1:0] opc, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] val, input logic typed, input list_result_t typed_res);
		list_result_t r;
		while ($urandom_range(99) < idle_pct) begin
			request_valid <= 1'b0;
			@(posedge clk);
		end
		request_valid <= 1'b1;
		opcode        <= opc;
		position      <= pos;
		value         <= val;
		@(posedge clk);
		while (request_stall)
			@(posedge clk);
		r = apply_list_op(opc, pos, val);
		pending_results.push_back(typed ? typed_res : r);
		requests_sent++;
	endtask

	// mostly well-formed positions; grow mode fills the list, shrink mode drains it
	task automatic send_random(input bit grow);
		int                  roll;
		logic [OPCODE_W-1:0] opc;
		logic [POS_W-1:0]    pos;
		logic [VALUE_W-1:0]  val;
		roll = $urandom_range(999);
		if (roll < 4)
			opc = OP_CLEAR;
		else if (roll < 20)
			opc = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		else if (roll < (grow ? 370 : 170))
			opc = OP_INSERT;
		else if (roll < (grow ? 570 : 270))
			opc = OP_APPEND;
		else if (roll < 720)
			opc = OP_DELETE;
		else
			opc = OP_GET;
		if ($urandom_range(9) == 0) begin
			pos = POS_W'($urandom_range(POS_MAX));
		end else begin
			case (opc)
			OP_INSERT: pos = POS_W'($urandom_range(list_len + 1, 1));
			OP_DELETE: pos = (list_len == 0) ? POS_W'(1) : POS_W'($urandom_range(list_len, 1));
			OP_GET:    pos = (list_len == 0) ? '0 : POS_W'($urandom_range(list_len - 1, 0));
			default:   pos = POS_W'($urandom_range(POS_MAX));
			endcase
		end
		case ($urandom_range(7))
		0:       val = ALL_ONES;
		1:       val = '0;
		default: val = $urandom;
		endcase
		send_request(opc, pos, val, 1'b0, NO_CHECK);
		random_sent++;
	endtask

	task automatic run_phase(input int sender_idle, input int receiver_stall, input int n);
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		repeat (n)
			send_random(((random_sent / 60) % 2) == 0);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		list_result_t want;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			results_seen++;
			status_seen[status]++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_LIMIT)
					$display("cycle %0d: result with no request waiting: rd %h st %0d cnt %0d",
						cycle_count, read_value, status, count);
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.rd || status !== want.st || count !== want.cnt
						|| is_empty !== want.empty) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT)
						$display("cycle %0d: expected rd %h st %0d cnt %0d empty %0d, got rd %h st %0d cnt %0d empty %0d",
							cycle_count, want.rd, want.st, want.cnt, want.empty,
							read_value, status, count, is_empty);
				end
			end
		end
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_table[i].reps != 0) begin
				for (int j = 0; j < dir_table[i].reps; j++)
					send_request(dir_table[i].opc, dir_table[i].pos, $urandom, 1'b0, NO_CHECK);
			end else begin
				send_request(dir_table[i].opc, dir_table[i].pos, dir_table[i].val,
					dir_table[i].typed, dir_table[i].res);
			end
		end

		run_phase(0, 0, 250);
		run_phase(85, 0, 200);
		run_phase(0, 85, 200);
		run_phase(24, 24, 250);
		// long output hold while requests keep coming, so the input backs up
		hold_cycles = 400;
		run_phase(0, 0, 230);

		request_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d requests (%0d random), checked %0d results; list peaked at %0d of %0d",
			requests_sent, random_sent, results_seen, peak_len, LIST_CAP);
		$display("status mix: ok %0d, full %0d, bad position %0d, empty %0d; mismatches %0d",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
			status_seen[ST_EMPTY], mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
